// ===== rtl/bppr_pkg.sv =====
`default_nettype none
package bppr_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int HW_FRAMES      = 16;
    localparam int CNT_W          = 7;

    localparam logic [7:0] PIN_MAX = 8'd255;

    localparam logic [2:0] OP_PIN   = 3'd0;
    localparam logic [2:0] OP_UNPIN = 3'd1;
    localparam logic [2:0] OP_DIRTY = 3'd2;
    localparam logic [2:0] OP_FORCE = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_NOT_RES  = 2'd2;

    localparam logic [1:0] STRAT_FIFO = 2'd0;
    localparam logic [1:0] STRAT_LRU  = 2'd1;

    localparam logic REG_STRATEGY = 1'b0;
    localparam logic REG_FRAMES   = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] page_number;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame_index;
        logic        hit;
        logic        writeback_valid;
        logic [15:0] writeback_page;
        logic        fill_valid;
        logic [31:0] read_total;
        logic [31:0] write_total;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       used;
        logic       dirty;
        logic       ref_bit;
        logic [7:0] pin;
    } t_flags;

    typedef enum logic [2:0] {
        C_HOLD,
        C_LOAD,
        C_SHIFT,
        C_CLR_REF,
        C_CLR_DIRTY,
        C_DEC_PIN,
        C_SET_DIRTY,
        C_CLEAR
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/bppr_cell.sv =====
`default_nettype none
module bppr_cell #(
    parameter int IDX       = 0,
    parameter int FW        = 4,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire bppr_pkg::t_cell_op     i_op,
    input  wire logic [PAGE_BITS-1:0]   i_key,
    input  wire logic [PAGE_BITS-1:0]   i_left_page,
    input  wire logic [FW-1:0]          i_left_frame,
    input  wire bppr_pkg::t_flags       i_left_flags,
    input  wire logic [PAGE_BITS-1:0]   i_new_page,
    input  wire logic [FW-1:0]          i_new_frame,
    input  wire bppr_pkg::t_flags       i_new_flags,
    output logic [PAGE_BITS-1:0]        o_page,
    output logic [FW-1:0]               o_frame,
    output bppr_pkg::t_flags            o_flags,
    output logic                        o_match
);
    import bppr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic [FW-1:0]        r_frame;
    t_flags               r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FW'(IDX);
            r_flags <= '0;
        end else begin
            case (i_op)
                C_LOAD: begin
                    r_page  <= i_new_page;
                    r_frame <= i_new_frame;
                    r_flags <= i_new_flags;
                end
                C_SHIFT: begin
                    r_page  <= i_left_page;
                    r_frame <= i_left_frame;
                    r_flags <= i_left_flags;
                end
                C_CLR_REF:   r_flags.ref_bit <= 1'b0;
                C_CLR_DIRTY: r_flags.dirty <= 1'b0;
                C_DEC_PIN:   r_flags.pin <= r_flags.pin - 8'd1;
                C_SET_DIRTY: r_flags.dirty <= 1'b1;
                C_CLEAR: begin
                    r_frame <= FW'(IDX);
                    r_flags <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_page  = r_page;
    assign o_frame = r_frame;
    assign o_flags = r_flags;
    assign o_match = r_flags.used && (r_page == i_key);

endmodule
`default_nettype wire

// ===== rtl/buffer_pool_page_replacement.sv =====
// Buffer pool page-frame table with FIFO, LRU and CLOCK replacement.
// Input channel (i_in_valid / o_in_ready) carries one request word: opcode
// and page number. Output channel (o_out_valid / i_out_ready) returns result
// words; the last word of a request has last set. Flush all returns one word
// per dirty frame, front to tail of the order.
// Frames live in a row of cells ordered by replacement position; a move to
// the front shifts the cells ahead of the moved frame one step down the row.
// One request at a time: accept, an execute step that searches the row and
// updates it, then the result register is shown. Each further flush word
// passes through the execute step and the result register again.
// A stalled receiver holds the result word and the block takes no request.
// Reset (and a write of frames_in_use) empties the pool and zeroes the read
// and write totals at once; a strategy write keeps the pool.
// Config port: i_cfg_we with i_cfg_idx 0 = strategy, 1 = frames_in_use.
`default_nettype none
module buffer_pool_page_replacement #(
    parameter int NUM_FRAMES = bppr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = bppr_pkg::PAGE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire bppr_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output bppr_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [4:0]     i_cfg_data
);
    import bppr_pkg::*;

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int MAXP = (NUM_FRAMES < HW_FRAMES) ? NUM_FRAMES : HW_FRAMES;

    t_state               r_state, n_state;
    logic [1:0]           r_strat;
    logic [4:0]           r_cfg_frames;
    logic [4:0]           r_filled, n_filled;
    logic [31:0]          r_reads, n_reads;
    logic [31:0]          r_writes, n_writes;
    logic [2:0]           r_op;
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_more, n_more;
    t_out                 r_out, n_out;

    logic [CNT_W-1:0]     pool_n;
    logic                 exec_en;

    logic [PAGE_BITS-1:0] c_page  [NUM_FRAMES];
    logic [FW-1:0]        c_frame [NUM_FRAMES];
    t_flags               c_flags [NUM_FRAMES];
    logic                 c_match [NUM_FRAMES];
    t_cell_op             c_op    [NUM_FRAMES];

    logic [PAGE_BITS-1:0] new_page;
    logic [FW-1:0]        new_frame;
    t_flags               new_flags;

    // pool size: at least one frame, at most the row or the hardware limit
    always_comb begin
        if (r_cfg_frames == 5'd0) begin
            pool_n = CNT_W'(1);
        end else if (CNT_W'(r_cfg_frames) > CNT_W'(MAXP)) begin
            pool_n = CNT_W'(MAXP);
        end else begin
            pool_n = CNT_W'(r_cfg_frames);
        end
    end

    // row of cells, each fed by its left neighbor; the head takes the new entry
    for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
        if (k == 0) begin : g_head
            bppr_cell #(.IDX(k), .FW(FW), .PAGE_BITS(PAGE_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (c_op[k]),
                .i_key       (r_page),
                .i_left_page (new_page),
                .i_left_frame(new_frame),
                .i_left_flags(new_flags),
                .i_new_page  (new_page),
                .i_new_frame (new_frame),
                .i_new_flags (new_flags),
                .o_page      (c_page[k]),
                .o_frame     (c_frame[k]),
                .o_flags     (c_flags[k]),
                .o_match     (c_match[k])
            );
        end else begin : g_body
            bppr_cell #(.IDX(k), .FW(FW), .PAGE_BITS(PAGE_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (c_op[k]),
                .i_key       (r_page),
                .i_left_page (c_page[k-1]),
                .i_left_frame(c_frame[k-1]),
                .i_left_flags(c_flags[k-1]),
                .i_new_page  (new_page),
                .i_new_frame (new_frame),
                .i_new_flags (new_flags),
                .o_page      (c_page[k]),
                .o_frame     (c_frame[k]),
                .o_flags     (c_flags[k]),
                .o_match     (c_match[k])
            );
        end
    end

    // execute: search the row, pick the action, build the result word
    always_comb begin
        logic [NUM_FRAMES-1:0] inpool, unp, dmask;
        logic          hit_any, tfound, cfound, ufound, dfound;
        logic [FW-1:0] hpos, tpos, cpos, upos, dpos, vpos, spos;
        logic          vfound, do_load, do_move, is_lru, fifo_lru;
        logic [NUM_FRAMES-1:0] clr_ref;
        t_cell_op      sop;

        hit_any = 1'b0; tfound = 1'b0; cfound = 1'b0; ufound = 1'b0; dfound = 1'b0;
        hpos = '0; tpos = '0; cpos = '0; upos = '0; dpos = '0; vpos = '0; spos = '0;
        vfound = 1'b0; do_load = 1'b0; do_move = 1'b0;
        clr_ref = '0;
        sop = C_HOLD;
        is_lru   = (r_strat == STRAT_LRU);
        fifo_lru = (r_strat == STRAT_FIFO) || is_lru;

        for (int k = 0; k < NUM_FRAMES; k++) begin
            inpool[k] = (CNT_W'(k) < pool_n);
            unp[k]    = inpool[k] && (c_flags[k].pin == 8'd0);
            dmask[k]  = inpool[k] && c_flags[k].used && c_flags[k].dirty;
            if (unp[k]) begin
                tfound = 1'b1;
                tpos   = FW'(k);
            end
        end
        for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
            if (c_match[k] && inpool[k]) begin
                hit_any = 1'b1;
                hpos    = FW'(k);
            end
            if (unp[k] && !c_flags[k].ref_bit) begin
                cfound = 1'b1;
                cpos   = FW'(k);
            end
            if (unp[k]) begin
                ufound = 1'b1;
                upos   = FW'(k);
            end
            if (dmask[k]) begin
                dfound = 1'b1;
                dpos   = FW'(k);
            end
        end

        n_out          = '0;
        n_out.last     = 1'b1;
        n_more         = 1'b0;
        n_filled       = r_filled;
        n_reads        = r_reads;
        n_writes       = r_writes;
        new_page  = c_page[hpos];
        new_frame = c_frame[hpos];
        new_flags = c_flags[hpos];

        case (r_op)
            OP_PIN: begin
                if (hit_any) begin
                    if (c_flags[hpos].pin != PIN_MAX) begin
                        new_flags.pin = c_flags[hpos].pin + 8'd1;
                    end
                    new_flags.ref_bit = 1'b1;
                    vpos    = hpos;
                    do_load = 1'b1;
                    do_move = is_lru;
                    n_out.frame_index = 4'(c_frame[hpos]);
                    n_out.hit         = 1'b1;
                end else begin
                    if (CNT_W'(r_filled) < pool_n) begin
                        vfound   = 1'b1;
                        vpos     = FW'(r_filled);
                        n_filled = r_filled + 5'd1;
                    end else if (fifo_lru) begin
                        vfound = tfound;
                        vpos   = tpos;
                    end else if (cfound) begin
                        // clear reference bits of unpinned frames ahead of it
                        vfound = 1'b1;
                        vpos   = cpos;
                        for (int k = 0; k < NUM_FRAMES; k++) begin
                            clr_ref[k] = unp[k] && (FW'(k) < cpos);
                        end
                    end else begin
                        vfound  = ufound;
                        vpos    = upos;
                        clr_ref = unp;
                    end
                    if (vfound) begin
                        if (c_flags[vpos].used && c_flags[vpos].dirty) begin
                            n_out.writeback_valid = 1'b1;
                            n_out.writeback_page  = 16'(c_page[vpos]);
                            n_writes = r_writes + 32'd1;
                        end
                        n_reads   = r_reads + 32'd1;
                        new_page  = r_page;
                        new_frame = c_frame[vpos];
                        new_flags = '{used: 1'b1, dirty: 1'b0, ref_bit: 1'b1, pin: 8'd1};
                        do_load   = 1'b1;
                        do_move   = fifo_lru;
                        n_out.frame_index = 4'(c_frame[vpos]);
                        n_out.fill_valid  = 1'b1;
                    end else begin
                        clr_ref      = '0;
                        n_out.status = ST_NO_FRAME;
                    end
                end
            end
            OP_UNPIN, OP_DIRTY, OP_FORCE: begin
                if (!hit_any || ((r_op == OP_UNPIN) && (c_flags[hpos].pin == 8'd0))) begin
                    n_out.status = ST_NOT_RES;
                end else begin
                    n_out.frame_index = 4'(c_frame[hpos]);
                    spos = hpos;
                    if (r_op == OP_UNPIN) begin
                        sop = C_DEC_PIN;
                    end else if (r_op == OP_DIRTY) begin
                        sop = C_SET_DIRTY;
                    end else begin
                        n_writes = r_writes + 32'd1;
                        n_out.writeback_valid = 1'b1;
                        n_out.writeback_page  = 16'(c_page[hpos]);
                    end
                end
            end
            OP_FLUSH: begin
                if (dfound) begin
                    spos = dpos;
                    sop  = C_CLR_DIRTY;
                    n_writes = r_writes + 32'd1;
                    n_out.frame_index     = 4'(c_frame[dpos]);
                    n_out.writeback_valid = 1'b1;
                    n_out.writeback_page  = 16'(c_page[dpos]);
                    // last word once no other dirty frame remains
                    n_out.last = ((dmask & ~(NUM_FRAMES'(1) << dpos)) == '0);
                    n_more     = !n_out.last;
                end
            end
            default: ;
        endcase

        n_out.read_total  = n_reads;
        n_out.write_total = n_writes;

        for (int k = 0; k < NUM_FRAMES; k++) begin
            c_op[k] = C_HOLD;
            if (i_cfg_we && (i_cfg_idx == REG_FRAMES)) begin
                c_op[k] = C_CLEAR;
            end else if (exec_en) begin
                if (clr_ref[k]) begin
                    c_op[k] = C_CLR_REF;
                end
                if ((sop != C_HOLD) && (FW'(k) == spos)) begin
                    c_op[k] = sop;
                end
                if (do_load) begin
                    if (do_move) begin
                        if (k == 0) begin
                            c_op[k] = C_LOAD;
                        end else if (FW'(k) <= vpos) begin
                            c_op[k] = C_SHIFT;
                        end
                    end else if (FW'(k) == vpos) begin
                        c_op[k] = C_LOAD;
                    end
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = r_more ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        exec_en     = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready  = 1'b1;
            S_EXEC: exec_en     = 1'b1;
            S_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strat      <= STRAT_FIFO;
            r_cfg_frames <= 5'd16;
            r_filled     <= '0;
            r_reads      <= '0;
            r_writes     <= '0;
            r_more       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx == REG_STRATEGY)) begin
                r_strat <= i_cfg_data[1:0];
            end
            if (i_cfg_we && (i_cfg_idx == REG_FRAMES)) begin
                r_cfg_frames <= i_cfg_data;
                r_filled     <= '0;
                r_reads      <= '0;
                r_writes     <= '0;
            end else if (exec_en) begin
                r_filled <= n_filled;
                r_reads  <= n_reads;
                r_writes <= n_writes;
            end
            if (exec_en) begin
                r_more <= n_more;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op   <= i_in_data.opcode;
            r_page <= PAGE_BITS'(i_in_data.page_number);
        end
        if (exec_en) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_filled) <= pool_n)
        else $error("fill count beyond pool size");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request taken while a word is pending");
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |-> !o_out_data.fill_valid
            && !o_out_data.writeback_valid)
        else $error("hit word carries storage traffic");
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.frame_index == 4'd0)
            && !o_out_data.fill_valid && o_out_data.last)
        else $error("failed request word not clean");
`endif

endmodule
`default_nettype wire
